// File: hw/rtl/pdf_structure_scanner_assert.svh
// assertion macros for the pdf structure scanner
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef PDF_STRUCTURE_SCANNER_ASSERT_SVH
`define PDF_STRUCTURE_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PSS_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PSS_ASSERT_CLK(label, clk, rst_n, prop)
`define PSS_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hw/rtl/pss_pkg.sv
// shared types, constants and pattern functions for the pdf structure scanner
// no dependencies
package pss_pkg;
	localparam int LinearWindow = 4096;
	localparam int CountWindow  = 512;
	localparam int VersionLimit = 12;
	localparam logic [23:0] PageMax = 24'hFFFFFF;
	localparam logic [31:0] MagicPdf = 32'h25504446;

	// pattern identifiers for the prefix matchers
	localparam logic [2:0] PatIdType    = 3'd0;
	localparam logic [2:0] PatIdPage    = 3'd1;
	localparam logic [2:0] PatIdCount   = 3'd2;
	localparam logic [2:0] PatIdSpaced  = 3'd3;
	localparam logic [2:0] PatIdCompact = 3'd4;
	localparam logic [2:0] PatIdLinear  = 3'd5;
	localparam logic [2:0] PatIdEncrypt = 3'd6;

	localparam logic [39:0] StrType    = "/Type";
	localparam logic [39:0] StrPage    = "/Page";
	localparam logic [55:0] StrCount   = "/Count ";
	localparam logic [95:0] StrSpaced  = "/Type /Pages";
	localparam logic [87:0] StrCompact = "/Type/Pages";
	localparam logic [87:0] StrLinear  = "/Linearized";
	localparam logic [63:0] StrEncrypt = "/Encrypt";

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic        magic_ok;
		logic [31:0] magic_bytes;
		logic        short_file;
		logic [27:0] version_text;
		logic [2:0]  version_length;
		logic [23:0] page_count;
		logic        linearized;
		logic        encrypted;
		logic [31:0] file_size;
	} out_req_t;

	// summary of the scan of one file
	typedef struct packed {
		logic        magic_ok;
		logic        short_file;
		logic [31:0] head;
		logic        ver_ok;
		logic [27:0] ver_nib;
		logic [2:0]  ver_cnt;
		logic [23:0] pages;
		logic        lin;
		logic        enc;
		logic [31:0] size;
	} scan_sum_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C
			|| c == 8'h0D || c == 8'h20;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// pattern byte tables, index from 0, zero beyond the pattern end
	function automatic logic [7:0] pat_char(input logic [2:0] id, input logic [3:0] k);
		logic [7:0] r;
		int         i;
		r = 8'h00;
		i = int'(k);
		case (id)
			PatIdType:    if (i < 5)  r = StrType[8*(4-i) +: 8];
			PatIdPage:    if (i < 5)  r = StrPage[8*(4-i) +: 8];
			PatIdCount:   if (i < 7)  r = StrCount[8*(6-i) +: 8];
			PatIdSpaced:  if (i < 12) r = StrSpaced[8*(11-i) +: 8];
			PatIdCompact: if (i < 11) r = StrCompact[8*(10-i) +: 8];
			PatIdLinear:  if (i < 11) r = StrLinear[8*(10-i) +: 8];
			PatIdEncrypt: if (i < 8)  r = StrEncrypt[8*(7-i) +: 8];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// prefix-tracking step: longest prefix of pattern ending at pat[0..p-1],c
	function automatic logic [3:0] advance(input logic [2:0] id, input logic [3:0] len,
			input logic [3:0] p_in, input logic [7:0] c);
		logic [3:0] p, r;
		logic       ok;
		p = (p_in >= len) ? 4'd0 : p_in;
		r = 4'd0;
		for (int k = 1; k <= 12; k++) begin
			ok = (k <= int'(p) + 1) && (k <= int'(len));
			for (int j = 0; j < 12; j++) begin
				if (j < k - 1) begin
					if (pat_char(id, 4'(int'(p) - k + 1 + j)) != pat_char(id, 4'(j)))
						ok = 1'b0;
				end
			end
			if (ok && c != pat_char(id, 4'(k - 1))) ok = 1'b0;
			if (ok) r = 4'(k);
		end
		return r;
	endfunction
endpackage

// File: hw/rtl/pss_tree.sv
// fallback "/Count" tracker following one "/Pages" tag pattern
// depends on pss_pkg
module pss_tree import pss_pkg::*; #(
	parameter int COUNT_WINDOW = CountWindow,
	parameter logic [2:0] PAT_ID = PatIdSpaced,
	parameter int PAT_LEN = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       clear,
	input  logic [7:0] c,
	output logic       found,
	output logic [23:0] value
);
	localparam int OffW = $clog2(COUNT_WINDOW + 1);
	typedef enum logic [2:0] {TR_TAG, TR_COUNT, TR_SPACE, TR_DIGITS, TR_DONE} tr_t;
	tr_t        phase_q, phase_n;
	logic [3:0] tag_q, tag_n, cnt_q, cnt_n, adv_t, adv_c;
	logic [OffW-1:0] off_q, off_n;
	logic [23:0] val_q, val_n;
	logic [27:0] prod;

	assign adv_t = advance(PAT_ID, 4'(PAT_LEN), tag_q, c);
	assign adv_c = advance(PatIdCount, 4'd7, cnt_q, c);
	assign prod = 28'(val_q) * 28'd10 + 28'(c - 8'h30);
	// state after the current byte, so a report can include the last byte
	assign found = phase_n != TR_TAG;
	assign value = val_n;

	always_comb begin
		phase_n = phase_q; tag_n = tag_q; cnt_n = cnt_q; off_n = off_q; val_n = val_q;
		case (phase_q)
			TR_TAG: begin
				tag_n = adv_t;
				if (adv_t == 4'(PAT_LEN)) begin
					phase_n = TR_COUNT; off_n = OffW'(PAT_LEN); cnt_n = '0;
				end
			end
			TR_COUNT: begin
				if (off_q >= OffW'(COUNT_WINDOW)) phase_n = TR_DONE;
				else begin
					cnt_n = adv_c;
					if (adv_c == 4'd7) phase_n = TR_SPACE;
					off_n = off_q + 1'b1;
				end
			end
			TR_SPACE: begin
				if (!is_space(c)) begin
					if (is_digit(c)) begin
						val_n = 24'(c - 8'h30); phase_n = TR_DIGITS;
					end else phase_n = TR_DONE;
				end
			end
			TR_DIGITS: begin
				if (is_digit(c)) val_n = (prod > 28'(PageMax)) ? PageMax : prod[23:0];
				else phase_n = TR_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TR_TAG; tag_q <= '0; cnt_q <= '0; off_q <= '0; val_q <= '0;
		end else if (step) begin
			if (clear) begin
				phase_q <= TR_TAG; tag_q <= '0; cnt_q <= '0; off_q <= '0; val_q <= '0;
			end else begin
				phase_q <= phase_n; tag_q <= tag_n; cnt_q <= cnt_n; off_q <= off_n;
				val_q <= val_n;
			end
		end
	end
endmodule

// File: hw/rtl/pss_leaf.sv
// leaf "/Type /Page" counter
// depends on pss_pkg
module pss_leaf import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        clear,
	input  logic [7:0]  c,
	output logic [23:0] pages
);
	typedef enum logic [1:0] {PH_TYPE, PH_SPACE, PH_PAGE, PH_AFTER} ph_t;
	ph_t        ph_q, ph_n;
	logic [3:0] tp_q, tp_n, pp_q, pp_n, adv, rescan, restart;
	logic [23:0] cnt_q, cnt_n;

	assign adv = advance(PatIdType, 4'd5, tp_q, c);
	// rescan for "/Type" over the failed "/Page" prefix: the '/' survives only alone
	assign rescan = advance(PatIdType, 4'd5, (pp_q == 4'd1) ? 4'd1 : 4'd0, c);
	assign restart = advance(PatIdType, 4'd5, 4'd0, c);
	// count after the current byte; an open "/Page" at end of file counts as a leaf
	assign pages = (ph_n == PH_AFTER && cnt_n != PageMax) ? cnt_n + 1'b1 : cnt_n;

	always_comb begin
		ph_n = ph_q; tp_n = tp_q; pp_n = pp_q; cnt_n = cnt_q;
		case (ph_q)
			PH_SPACE: begin
				if (!is_space(c)) begin
					if (c == "/") begin ph_n = PH_PAGE; pp_n = 4'd1; end
					else begin ph_n = PH_TYPE; tp_n = '0; end
				end
			end
			PH_PAGE: begin
				if (c == pat_char(PatIdPage, pp_q)) begin
					pp_n = pp_q + 1'b1;
					if (pp_q >= 4'd4) ph_n = PH_AFTER;
				end else begin
					tp_n = rescan; ph_n = PH_TYPE;
				end
			end
			PH_AFTER: begin
				ph_n = PH_TYPE;
				tp_n = '0;
				if (c != "s") begin
					if (cnt_q != PageMax) cnt_n = cnt_q + 1'b1;
					tp_n = restart;
				end
			end
			default: begin
				if (adv == 4'd5) begin ph_n = PH_SPACE; tp_n = '0; end
				else begin ph_n = PH_TYPE; tp_n = adv; end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_TYPE; tp_q <= '0; pp_q <= '0; cnt_q <= '0;
		end else if (step) begin
			if (clear) begin
				ph_q <= PH_TYPE; tp_q <= '0; pp_q <= '0; cnt_q <= '0;
			end else begin
				ph_q <= ph_n; tp_q <= tp_n; pp_q <= pp_n; cnt_q <= cnt_n;
			end
		end
	end
endmodule

// File: hw/rtl/pdf_structure_scanner.sv
// pdf structure scanner top level: header, version, flag matchers and report register
// depends on pss_pkg, pss_leaf, pss_tree and pdf_structure_scanner_assert.svh
//
// takes a file one byte per request and gives one report request on the byte
// flagged last, then returns to its reset state for the next file. one byte
// is taken every cycle while the skid slot is empty: each byte updates a
// handful of small prefix matchers in a single step, and the report sits in
// an output register with a skid stage, so input is still taken while a
// report waits to be collected.
`include "pdf_structure_scanner_assert.svh"
module pdf_structure_scanner import pss_pkg::*; #(
	parameter int LINEAR_WINDOW = LinearWindow,
	parameter int COUNT_WINDOW  = CountWindow,
	parameter int VERSION_LIMIT = VersionLimit
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_data
);
	logic        step, last;
	logic [7:0]  c;
	logic [31:0] pos_q, head_q, size_n;
	logic        dash_q, vstop_q, lin_q, enc_q;
	logic [27:0] vnib_q;
	logic [2:0]  vcnt_q;
	logic [3:0]  linp_q, encp_q, lin_adv, enc_adv;
	logic [23:0] leaf_pages, sp_val, cp_val;
	logic        sp_found, cp_found;
	// output register plus skid slot
	logic        ov_q, sv_q;
	out_req_t    od_q, sd_q, rep;
	logic [31:0] head_n;
	logic        vs_n;
	logic [27:0] vn_n;
	logic [2:0]  vc_n;
	logic        lin_n, enc_n, valid_f, ver;
	logic [23:0] pg;

	assign in_ready = !sv_q;
	assign step = in_valid && in_ready;
	assign c = in_data.data_byte;
	assign last = in_data.last_byte;
	assign out_valid = ov_q;
	assign out_data = od_q;

	// matchers for the two flags
	assign lin_adv = advance(PatIdLinear, 4'd11, linp_q, c);
	assign enc_adv = advance(PatIdEncrypt, 4'd8, encp_q, c);

	// next values of the header and version state, used both for update and report
	always_comb begin
		head_n = (pos_q < 32'd4) ? {head_q[23:0], c} : head_q;
		vs_n = vstop_q; vn_n = vnib_q; vc_n = vcnt_q;
		if (pos_q >= 32'd5 && pos_q < 32'(VERSION_LIMIT) && !vstop_q) begin
			if ((is_digit(c) || c == ".") && vcnt_q < 3'd7) begin
				vn_n[4*vcnt_q +: 4] = (c == ".") ? 4'd10 : 4'(c - 8'h30);
				vc_n = vcnt_q + 1'b1;
				if (vc_n == 3'd7) vs_n = 1'b1;
			end else vs_n = 1'b1;
		end
		lin_n = lin_q || (lin_adv == 4'd11 && pos_q < 32'(LINEAR_WINDOW));
		enc_n = enc_q || enc_adv == 4'd8;
		size_n = (pos_q != 32'hFFFFFFFF) ? pos_q + 1'b1 : pos_q;
	end

	// leaf counter and tree trackers give their state after the current byte,
	// so a report built on the last byte already includes it
	pss_leaf u_leaf (.clk, .arst_n, .step, .clear(last), .c, .pages(leaf_pages));
	pss_tree #(.COUNT_WINDOW(COUNT_WINDOW), .PAT_ID(PatIdSpaced), .PAT_LEN(12)) u_spaced (
		.clk, .arst_n, .step, .clear(last), .c, .found(sp_found), .value(sp_val));
	pss_tree #(.COUNT_WINDOW(COUNT_WINDOW), .PAT_ID(PatIdCompact), .PAT_LEN(11)) u_compact (
		.clk, .arst_n, .step, .clear(last), .c, .found(cp_found), .value(cp_val));

	// report for a last byte
	always_comb begin
		valid_f = size_n >= 32'd4 && head_n == MagicPdf;
		ver = valid_f && size_n >= 32'd8 && dash_q && vc_n != 3'd0;
		pg = '0;
		if (valid_f) begin
			pg = leaf_pages;
			if (pg == '0) begin
				if (sp_found) pg = sp_val;
				else if (cp_found) pg = cp_val;
			end
		end
		rep.magic_ok = valid_f;
		rep.magic_bytes = (size_n < 32'd4) ? 32'd0 : head_n;
		rep.short_file = size_n < 32'd4;
		rep.version_text = ver ? vn_n : 28'hFFFFFFF;
		rep.version_length = ver ? vc_n : 3'd0;
		rep.page_count = pg;
		rep.linearized = valid_f && lin_n;
		rep.encrypted = valid_f && enc_n;
		rep.file_size = size_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; head_q <= '0; dash_q <= 1'b0; vnib_q <= '1; vcnt_q <= '0;
			vstop_q <= 1'b0; linp_q <= '0; lin_q <= 1'b0; encp_q <= '0; enc_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				pos_q <= '0; head_q <= '0; dash_q <= 1'b0; vnib_q <= '1; vcnt_q <= '0;
				vstop_q <= 1'b0; linp_q <= '0; lin_q <= 1'b0; encp_q <= '0; enc_q <= 1'b0;
			end else begin
				pos_q <= size_n; head_q <= head_n;
				if (pos_q == 32'd4) dash_q <= c == "-";
				vnib_q <= vn_n; vcnt_q <= vc_n; vstop_q <= vs_n;
				lin_q <= lin_n; enc_q <= enc_n;
				if (!lin_q) linp_q <= (lin_adv == 4'd11) ? 4'd0 : lin_adv;
				if (!enc_q) encp_q <= (enc_adv == 4'd8) ? 4'd0 : enc_adv;
			end
		end
	end

	// output register with one skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; sv_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= sv_q || (step && last);
				sv_q <= 1'b0;
			end else if (step && last) begin
				if (ov_q) sv_q <= 1'b1;
				else ov_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ov_q && out_ready) od_q <= sv_q ? sd_q : rep;
		else if (step && last && !ov_q) od_q <= rep;
		if (step && last && ov_q && !out_ready) sd_q <= rep;
	end

	`PSS_ASSERT_CLK(a_skid_needs_out, clk, arst_n, sv_q |-> ov_q)
	`PSS_ASSERT_CLK(a_no_take_when_full, clk, arst_n, sv_q |-> !in_ready)
	`PSS_ASSERT_CLK(a_report_follows_last, clk, arst_n, (step && last && !ov_q) |=> ov_q)
endmodule

// File: tb/pss_checker.sv
// report checker for the pdf structure scanner: mirrors the byte scan and compares reports
// depends on pss_pkg (in_req_t, out_req_t, MagicPdf, PageMax, VersionLimit, LinearWindow, CountWindow)
`timescale 1ns / 1ps
module pss_checker import pss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  in_req_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  out_req_t out_data,
	output int       fail_count,
	output int       pending,
	output int       reports_seen
);
	typedef enum logic [1:0] {LEAF_TYPE, LEAF_SPACE, LEAF_PAGE, LEAF_AFTER} leaf_phase_e;
	typedef enum logic [2:0] {TREE_TAG, TREE_COUNT, TREE_SPACE, TREE_DIGITS, TREE_DONE}
		tree_phase_e;

	typedef struct {
		tree_phase_e phase;
		int          tag_prog;
		int          cnt_prog;
		int          offset;
		logic [23:0] value;
	} tree_t;

	localparam string PatType    = "/Type";
	localparam string PatPage    = "/Page";
	localparam string PatCount   = "/Count ";
	localparam string PatSpaced  = "/Type /Pages";
	localparam string PatCompact = "/Type/Pages";
	localparam string PatLinear  = "/Linearized";
	localparam string PatEncrypt = "/Encrypt";

	logic [31:0] pos, head, ver_nib;
	logic        dash, ver_stop, lin_seen, enc_seen;
	int          ver_cnt, type_prog, page_prog, lin_prog, enc_prog;
	leaf_phase_e leaf_phase;
	logic [23:0] leaf_count;
	tree_t       spaced, compact;
	out_req_t    report_q[$];

	// longest prefix of pat ending the text pat[0..p-1] followed by c
	function automatic int prefix_step(string pat, int p, logic [7:0] c);
		string buf_s;
		int    n;
		if (p >= pat.len()) p = 0;
		buf_s = {pat.substr(0, p - 1), string'(c)};
		if (p == 0) buf_s = string'(c);
		n = p + 1;
		for (int k = (n < pat.len() ? n : pat.len()); k > 0; k--)
			if (buf_s.substr(n - k, n - 1) == pat.substr(0, k - 1)) return k;
		return 0;
	endfunction

	function automatic logic ws(logic [7:0] c);
		return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D
			|| c == 8'h20;
	endfunction

	function automatic logic dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic clear_scan();
		pos = 0; head = 0; dash = 0; ver_nib = 32'h0FFFFFFF; ver_cnt = 0; ver_stop = 0;
		leaf_phase = LEAF_TYPE; type_prog = 0; page_prog = 0; leaf_count = 0;
		spaced = '{TREE_TAG, 0, 0, 0, 24'd0}; compact = spaced;
		lin_prog = 0; lin_seen = 0; enc_prog = 0; enc_seen = 0;
	endtask

	task automatic tree_step(inout tree_t t, input string pat, input logic [7:0] c);
		logic [31:0] v;
		case (t.phase)
			TREE_TAG: begin
				t.tag_prog = prefix_step(pat, t.tag_prog, c);
				if (t.tag_prog == pat.len()) begin
					t.phase = TREE_COUNT; t.offset = pat.len(); t.cnt_prog = 0;
				end
			end
			TREE_COUNT: begin
				if (t.offset >= CountWindow) t.phase = TREE_DONE;
				else begin
					t.cnt_prog = prefix_step(PatCount, t.cnt_prog, c);
					if (t.cnt_prog == 7) t.phase = TREE_SPACE;
					t.offset++;
				end
			end
			TREE_SPACE: begin
				if (!ws(c)) begin
					if (dig(c)) begin t.value = c - "0"; t.phase = TREE_DIGITS; end
					else t.phase = TREE_DONE;
				end
			end
			TREE_DIGITS: begin
				if (dig(c)) begin
					v = t.value * 10 + (c - "0");
					t.value = v > PageMax ? PageMax : v[23:0];
				end else t.phase = TREE_DONE;
			end
			default: ;
		endcase
	endtask

	task automatic leaf_step(logic [7:0] c);
		case (leaf_phase)
			LEAF_SPACE: begin
				if (!ws(c)) begin
					if (c == "/") begin leaf_phase = LEAF_PAGE; page_prog = 1; end
					else begin leaf_phase = LEAF_TYPE; type_prog = 0; end
				end
			end
			LEAF_PAGE: begin
				if (c == PatPage[page_prog]) begin
					page_prog++;
					if (page_prog >= 5) leaf_phase = LEAF_AFTER;
				end else begin
					// rescan for the type tag from the start of the failed token
					type_prog = 0;
					for (int k = 0; k < page_prog; k++)
						type_prog = prefix_step(PatType, type_prog, PatPage[k]);
					type_prog = prefix_step(PatType, type_prog, c);
					leaf_phase = LEAF_TYPE;
				end
			end
			LEAF_AFTER: begin
				leaf_phase = LEAF_TYPE; type_prog = 0;
				if (c != "s") begin
					if (leaf_count != PageMax) leaf_count++;
					type_prog = prefix_step(PatType, 0, c);
				end
			end
			default: begin
				type_prog = prefix_step(PatType, type_prog, c);
				if (type_prog == 5) begin leaf_phase = LEAF_SPACE; type_prog = 0; end
			end
		endcase
	endtask

	task automatic scan_byte(in_req_t r);
		logic [7:0] c;
		logic       valid, shortf, ver;
		logic [23:0] pages;
		out_req_t   rep;
		c = r.data_byte;
		if (pos < 4) head = {head[23:0], c};
		if (pos == 4) dash = (c == "-");
		if (pos >= 5 && pos < VersionLimit && !ver_stop) begin
			if ((dig(c) || c == ".") && ver_cnt < 7) begin
				ver_nib[4*ver_cnt +: 4] = (c == ".") ? 4'd10 : 4'(c - "0");
				ver_cnt++;
				if (ver_cnt >= 7) ver_stop = 1;
			end else ver_stop = 1;
		end
		leaf_step(c);
		tree_step(spaced, PatSpaced, c);
		tree_step(compact, PatCompact, c);
		if (!lin_seen) begin
			lin_prog = prefix_step(PatLinear, lin_prog, c);
			if (lin_prog == 11) begin
				if (pos < LinearWindow) lin_seen = 1;
				lin_prog = 0;
			end
		end
		if (!enc_seen) begin
			enc_prog = prefix_step(PatEncrypt, enc_prog, c);
			if (enc_prog == 8) begin enc_seen = 1; enc_prog = 0; end
		end
		if (pos != 32'hFFFFFFFF) pos++;
		if (!r.last_byte) return;
		shortf = pos < 4;
		valid = !shortf && head == MagicPdf;
		ver = valid && pos >= 8 && dash && ver_cnt > 0;
		pages = 0;
		if (valid) begin
			// a page tag right at the end of the file still counts
			if (leaf_phase == LEAF_AFTER && leaf_count != PageMax) leaf_count++;
			pages = leaf_count;
			if (pages == 0) begin
				if (spaced.phase != TREE_TAG) pages = spaced.value;
				else if (compact.phase != TREE_TAG) pages = compact.value;
			end
		end
		rep.magic_ok       = valid;
		rep.magic_bytes    = shortf ? 32'd0 : head;
		rep.short_file     = shortf;
		rep.version_text   = ver ? ver_nib[27:0] : 28'hFFFFFFF;
		rep.version_length = ver ? 3'(ver_cnt) : 3'd0;
		rep.page_count     = pages;
		rep.linearized     = valid && lin_seen;
		rep.encrypted      = valid && enc_seen;
		rep.file_size      = pos;
		report_q.push_back(rep);
		clear_scan();
	endtask

	initial begin
		clear_scan();
		fail_count = 0;
		reports_seen = 0;
	end

	always @(posedge clk) begin
		out_req_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				reports_seen <= reports_seen + 1;
				if (report_q.size() == 0) begin
					$display("%0t: report with none expected: %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = report_q.pop_front();
					if (exp_r !== out_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) scan_byte(in_data);
		end
		pending <= report_q.size();
	end
endmodule

// File: tb/tb_top.sv
// stimulus and verdict for the pdf structure scanner testbench
// depends on pss_pkg, pss_checker and the scanner rtl
`timescale 1ns / 1ps
module tb_top;
	import pss_pkg::*;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     in_valid = 0;
	logic     in_ready;
	in_req_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 0;
	out_req_t out_data;
	int       fail_count, pending, reports_seen;
	int       send_idle = 0, recv_idle = 0;
	int       bytes_sent = 0;
	longint   cycle = 0;
	logic [7:0] file_buf[$];

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	pdf_structure_scanner u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	pss_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending), .reports_seen(reports_seen)
	);

	// watchdog: every byte may see a long stall on both sides
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("timeout after %0d cycles", cycle);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver stalls at random by the current idle percentage
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	// push one byte as a request, honouring sender idling
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_byte: b, last_byte: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_buf.size(); i++)
			send_byte(file_buf[i], i == file_buf.size() - 1);
		in_valid <= 0;
		file_buf.delete();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
	endtask

	function automatic string pick_token();
		string toks[16];
		toks = '{"/Type /Page ", "/Type/Page\n", "/Type\t\r/Pages", "/Type /Pages",
			"/Type/Pages", "/Count 7", "/Count  12345678", "/Linearized", "/Encrypt",
			"/Type /Pag", "/Typ/Type /Page", "/Type /Page/Type", " 0 obj ", "/Count x",
			"/Lin/Linearized", "/Encryp/Encrypt"};
		return toks[$urandom_range(15)];
	endfunction

	// random file: mostly well formed with random tokens, some pure noise
	task automatic random_file();
		int kind, n;
		kind = $urandom_range(9);
		if (kind == 0) begin
			n = $urandom_range(1, 9);
			repeat (n) file_buf.push_back(8'($urandom));
		end else begin
			add_text(kind == 1 ? "%PDX-" : "%PDF-");
			n = $urandom_range(0, 8);
			repeat (n) file_buf.push_back($urandom_range(3) == 0 ? "." :
				8'("0" + $urandom_range(9)));
			if ($urandom_range(3) == 0) file_buf.push_back(8'($urandom));
			n = $urandom_range(0, 6);
			repeat (n) begin
				if ($urandom_range(2) == 0) file_buf.push_back(8'($urandom));
				else add_text(pick_token());
			end
		end
		send_file();
	endtask

	task automatic run_phase(int s_idle, int r_idle, int n_bytes);
		int goal;
		send_idle = s_idle;
		recv_idle = r_idle;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) random_file();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed files: short, bad magic, versions, leaves, fallbacks, flags
		file_buf.push_back(8'hFF); send_file();
		add_text("%PD"); send_file();
		add_text("%PDF"); send_file();
		add_text("\x00\xff%P"); send_file();
		add_text("%PDF-1.7"); send_file();
		add_text("%PDF-12.3.45.6"); send_file();
		add_text("%PDF_1.4 x"); send_file();
		add_text("%PDF-1.5/Type /Page /Type/Page"); send_file();
		add_text("%PDF-1/Type/Pages /Count 42 "); send_file();
		add_text("%PDF-2/Type /Pages/Count   99999999x"); send_file();
		add_text("%PDF-1.0 /Type/Page"); send_file();
		add_text("%PDF-1/Linearized/Encrypt"); send_file();
		add_text("%PDF-1 /Type /Pages "); repeat (520) file_buf.push_back("a");
		add_text("/Count 5 "); send_file();
		add_text("/Type /Page /Encrypt"); send_file();

		run_phase(34, 54, 270);
		run_phase(54, 34, 270);
		run_phase(0, 0, 260);

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d bytes and %0d reports, with idling on both sides",
			bytes_sent, reports_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_tree.sv
hw/rtl/pss_leaf.sv
hw/rtl/pdf_structure_scanner.sv
tb/pss_checker.sv
tb/tb_top.sv
